// ===== hdl/first_fit_resource_map_macros.svh =====
// ---------------------------------------------------------------------------
// first fit resource map assertion macros
// property forms for the map checker
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_RESOURCE_MAP_MACROS_SVH
`define FIRST_FIT_RESOURCE_MAP_MACROS_SVH

// same-cycle implication, off during reset
`define FFRM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("first fit map check failed");

// next-cycle implication, off during reset
`define FFRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("first fit map check failed");

`endif

// ===== hdl/ffrm_pkg.sv =====
// ---------------------------------------------------------------------------
// ffrm_pkg
// types, constants and control store of the first fit resource map
// ---------------------------------------------------------------------------
package ffrm_pkg;

  localparam int MAP_ENTRIES = 64;
  localparam int ADDR_BITS   = 16;
  localparam int IDX_W       = $clog2(MAP_ENTRIES);
  localparam int CNT_W       = $clog2(MAP_ENTRIES + 1);

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [ADDR_BITS:0]   addr_ext_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [IDX_W-1:0]     idx_t;

  localparam addr_ext_t ADDR_TOP  = {1'b1, {ADDR_BITS{1'b0}}};
  localparam cnt_t      SLOTS_MAX = cnt_t'(MAP_ENTRIES);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t  command;
    addr_t req_size;
    addr_t req_base;
  } req_t;

  typedef struct packed {
    addr_t   grant_base;
    status_t status;
    cnt_t    free_slots;
  } rsp_t;

  typedef struct packed {
    addr_t base;
    addr_t len;
  } ent_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_READ_IDX,
    OP_READ_IDX_P1,
    OP_READ_PTR_M1,
    OP_SKIP,
    OP_PREV,
    OP_TRIM,
    OP_SHIFT_DN,
    OP_CNT_DEC,
    OP_ST_NOFIT,
    OP_ST_FULL,
    OP_ST_ZERO,
    OP_EVAL,
    OP_PTR_CNT,
    OP_SHIFT_UP,
    OP_PUT,
    OP_LOW_WR,
    OP_MERGE3,
    OP_UP_WR,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_ZERO,
    C_FREE,
    C_IDX_END,
    C_NOT_FIT,
    C_LEN_NZ,
    C_LAST,
    C_BASE_LE,
    C_LOWER,
    C_UMERGE,
    C_FULL,
    C_PTR_AT_IDX,
    C_NOT_THREE,
    C_OUT_FREE
  } cond_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_DISP2,
    S_ASCAN,
    S_ACHECK,
    S_ATRIM,
    S_RM_LOOP,
    S_RM_WR,
    S_RM_END,
    S_NOFIT,
    S_FSCAN,
    S_FCHK,
    S_FEVAL,
    S_FD1,
    S_FD2,
    S_FD3,
    S_INS_SET,
    S_INS_LOOP,
    S_INS_WR,
    S_INS_PUT,
    S_FLOW,
    S_F3,
    S_FUP,
    S_FULL,
    S_ZERO,
    S_DONE,
    S_HOLD
  } step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctl_t;

  typedef struct packed {
    logic accept;
    logic zero;
    logic is_free;
    logic idx_end;
    logic not_fit;
    logic len_nz;
    logic last;
    logic base_le;
    logic lower;
    logic umerge;
    logic full;
    logic ptr_at_idx;
    logic not_three;
    logic out_free;
  } flags_t;

  function automatic ctl_t mk(input op_t op, input cond_t cond, input step_t target);
    ctl_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // microprogram: op, jump condition, jump target
  function automatic ctl_t ucode_rom(input step_t s);
    ctl_t w;
    w = mk(OP_NOP, C_ALWAYS, S_IDLE);
    unique case (s)
      S_IDLE:     w = mk(OP_LOAD,        C_NO_ACCEPT,  S_IDLE);
      S_DISP:     w = mk(OP_NOP,         C_ZERO,       S_ZERO);
      S_DISP2:    w = mk(OP_NOP,         C_FREE,       S_FSCAN);
      S_ASCAN:    w = mk(OP_READ_IDX,    C_IDX_END,    S_NOFIT);
      S_ACHECK:   w = mk(OP_SKIP,        C_NOT_FIT,    S_ASCAN);
      S_ATRIM:    w = mk(OP_TRIM,        C_LEN_NZ,     S_DONE);
      S_RM_LOOP:  w = mk(OP_READ_IDX_P1, C_LAST,       S_RM_END);
      S_RM_WR:    w = mk(OP_SHIFT_DN,    C_ALWAYS,     S_RM_LOOP);
      S_RM_END:   w = mk(OP_CNT_DEC,     C_ALWAYS,     S_DONE);
      S_NOFIT:    w = mk(OP_ST_NOFIT,    C_ALWAYS,     S_DONE);
      S_FSCAN:    w = mk(OP_READ_IDX,    C_IDX_END,    S_FEVAL);
      S_FCHK:     w = mk(OP_PREV,        C_BASE_LE,    S_FSCAN);
      S_FEVAL:    w = mk(OP_EVAL,        C_NEVER,      S_IDLE);
      S_FD1:      w = mk(OP_NOP,         C_LOWER,      S_FLOW);
      S_FD2:      w = mk(OP_NOP,         C_UMERGE,     S_FUP);
      S_FD3:      w = mk(OP_NOP,         C_FULL,       S_FULL);
      S_INS_SET:  w = mk(OP_PTR_CNT,     C_NEVER,      S_IDLE);
      S_INS_LOOP: w = mk(OP_READ_PTR_M1, C_PTR_AT_IDX, S_INS_PUT);
      S_INS_WR:   w = mk(OP_SHIFT_UP,    C_ALWAYS,     S_INS_LOOP);
      S_INS_PUT:  w = mk(OP_PUT,         C_ALWAYS,     S_DONE);
      S_FLOW:     w = mk(OP_LOW_WR,      C_NOT_THREE,  S_DONE);
      S_F3:       w = mk(OP_MERGE3,      C_ALWAYS,     S_RM_LOOP);
      S_FUP:      w = mk(OP_UP_WR,       C_ALWAYS,     S_DONE);
      S_FULL:     w = mk(OP_ST_FULL,     C_ALWAYS,     S_DONE);
      S_ZERO:     w = mk(OP_ST_ZERO,     C_ALWAYS,     S_DONE);
      S_DONE:     w = mk(OP_EMIT,        C_OUT_FREE,   S_IDLE);
      S_HOLD:     w = mk(OP_NOP,         C_ALWAYS,     S_DONE);
      default:    w = mk(OP_NOP,         C_ALWAYS,     S_IDLE);
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/ffrm_ifs.sv =====
// ---------------------------------------------------------------------------
// ffrm channel interfaces
// valid/ready channels for request and response words
// ---------------------------------------------------------------------------
interface ffrm_req_if import ffrm_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ffrm_rsp_if import ffrm_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/ffrm_useq.sv =====
// ---------------------------------------------------------------------------
// ffrm_useq
// step counter, control store and conditional jump logic
// ---------------------------------------------------------------------------
module ffrm_useq import ffrm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t fl,
  output ctl_t   ctl
);

  step_t upc_r;
  step_t upc_nxt;
  logic  take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // next step
  always_comb begin
    unique case (ctl.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_ACCEPT:  take = !fl.accept;
      C_ZERO:       take = fl.zero;
      C_FREE:       take = fl.is_free;
      C_IDX_END:    take = fl.idx_end;
      C_NOT_FIT:    take = fl.not_fit;
      C_LEN_NZ:     take = fl.len_nz;
      C_LAST:       take = fl.last;
      C_BASE_LE:    take = fl.base_le;
      C_LOWER:      take = fl.lower;
      C_UMERGE:     take = fl.umerge;
      C_FULL:       take = fl.full;
      C_PTR_AT_IDX: take = fl.ptr_at_idx;
      C_NOT_THREE:  take = fl.not_three;
      C_OUT_FREE:   take = fl.out_free;
      default:      take = 1'b0;
    endcase
    upc_nxt = take ? ctl.target : step_t'(upc_r + 1'b1);
  end

  // control word
  always_comb begin
    ctl = ucode_rom(upc_r);
  end

endmodule

// ===== hdl/ffrm_dp.sv =====
// ---------------------------------------------------------------------------
// ffrm_dp
// extent memory, scan pointers, merge arithmetic and response register
// ---------------------------------------------------------------------------
module ffrm_dp import ffrm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl,
  output flags_t            fl,
  ffrm_req_if.sink          in_req,
  ffrm_rsp_if.source        out_rsp
);

  ent_t      mem [MAP_ENTRIES];
  ent_t      rd_r;

  // control state
  cnt_t      cnt_r;
  cnt_t      slots_r;
  logic      out_valid_r;

  // working registers
  cmd_t      cmd_r;
  addr_t     size_r;
  addr_t     base_r;
  addr_ext_t end_r;
  cnt_t      idx_r;
  cnt_t      ptr_r;
  addr_t     prev_base_r;
  addr_t     prev_len_r;
  addr_ext_t acc_r;
  logic      lower_r;
  logic      upper_r;
  logic      umerge_r;
  addr_t     grant_r;
  status_t   status_r;
  rsp_t      out_r;

  logic      rd_en;
  idx_t      rd_addr;
  logic      wr_en;
  idx_t      wr_addr;
  ent_t      wr_data;

  cnt_t      idx_p1;
  cnt_t      idx_m1;
  cnt_t      ptr_m1;
  addr_ext_t in_sum;
  addr_ext_t clip_diff;
  logic      in_over;
  addr_ext_t low_end;
  addr_ext_t low_sum;
  addr_ext_t up_sum;
  addr_ext_t sum3;
  logic      upper_now;
  logic      emit;

  assign idx_p1    = idx_r + 1'b1;
  assign idx_m1    = idx_r - 1'b1;
  assign ptr_m1    = ptr_r - 1'b1;
  assign in_sum    = {1'b0, in_req.data.req_base} + {1'b0, in_req.data.req_size};
  assign clip_diff = ADDR_TOP - {1'b0, in_req.data.req_base};
  assign in_over   = in_sum > ADDR_TOP;
  assign low_end   = {1'b0, prev_base_r} + {1'b0, prev_len_r};
  assign low_sum   = {1'b0, prev_len_r} + {1'b0, size_r};
  assign up_sum    = {1'b0, rd_r.len} + {1'b0, size_r};
  assign sum3      = {1'b0, acc_r[ADDR_BITS-1:0]} + {1'b0, rd_r.len};
  assign upper_now = (idx_r < cnt_r) && (end_r == {1'b0, rd_r.base});

  assign in_req.ready  = (ctl.op == OP_LOAD);
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_r;
  assign emit          = (ctl.op == OP_EMIT) && fl.out_free;

  always_comb begin
    fl.accept     = in_req.valid && in_req.ready;
    fl.zero       = (size_r == '0);
    fl.is_free    = (cmd_r == CMD_FREE);
    fl.idx_end    = (idx_r == cnt_r);
    fl.not_fit    = (rd_r.len < size_r);
    fl.len_nz     = (rd_r.len != size_r);
    fl.last       = (idx_p1 >= cnt_r);
    fl.base_le    = (rd_r.base <= base_r);
    fl.lower      = lower_r;
    fl.umerge     = umerge_r;
    fl.full       = (slots_r == '0);
    fl.ptr_at_idx = (ptr_r == idx_r);
    fl.not_three  = !(upper_r && !sum3[ADDR_BITS]);
    fl.out_free   = !out_valid_r || out_rsp.ready;
  end

  // memory port controls
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_r[IDX_W-1:0];
    wr_data = rd_r;
    unique case (ctl.op)
      OP_READ_IDX: begin
        rd_en = 1'b1;
      end
      OP_READ_IDX_P1: begin
        rd_en   = 1'b1;
        rd_addr = idx_p1[IDX_W-1:0];
      end
      OP_READ_PTR_M1: begin
        rd_en   = 1'b1;
        rd_addr = ptr_m1[IDX_W-1:0];
      end
      OP_TRIM: begin
        wr_en        = 1'b1;
        wr_data.base = rd_r.base + size_r;
        wr_data.len  = rd_r.len - size_r;
      end
      OP_SHIFT_DN: begin
        wr_en = 1'b1;
      end
      OP_SHIFT_UP: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[IDX_W-1:0];
      end
      OP_PUT: begin
        wr_en        = 1'b1;
        wr_data.base = base_r;
        wr_data.len  = size_r;
      end
      OP_LOW_WR: begin
        wr_en        = 1'b1;
        wr_addr      = idx_m1[IDX_W-1:0];
        wr_data.base = prev_base_r;
        wr_data.len  = acc_r[ADDR_BITS-1:0];
      end
      OP_MERGE3: begin
        wr_en        = 1'b1;
        wr_addr      = idx_m1[IDX_W-1:0];
        wr_data.base = prev_base_r;
        wr_data.len  = sum3[ADDR_BITS-1:0];
      end
      OP_UP_WR: begin
        wr_en        = 1'b1;
        wr_data.base = base_r;
        wr_data.len  = up_sum[ADDR_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  // extent map
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      slots_r     <= SLOTS_MAX;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.op == OP_CNT_DEC) begin
        cnt_r   <= cnt_r - 1'b1;
        slots_r <= slots_r + 1'b1;
      end else if (ctl.op == OP_PUT) begin
        cnt_r   <= cnt_r + 1'b1;
        slots_r <= slots_r - 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LOAD: begin
        if (fl.accept) begin
          cmd_r    <= in_req.data.command;
          base_r   <= in_req.data.req_base;
          size_r   <= (in_req.data.command == CMD_FREE && in_over)
                      ? clip_diff[ADDR_BITS-1:0] : in_req.data.req_size;
          end_r    <= in_over ? ADDR_TOP : in_sum;
          idx_r    <= '0;
          grant_r  <= '0;
          status_r <= ST_DONE;
        end
      end
      OP_SKIP: begin
        if (fl.not_fit) begin
          idx_r <= idx_p1;
        end
      end
      OP_PREV: begin
        if (fl.base_le) begin
          prev_base_r <= rd_r.base;
          prev_len_r  <= rd_r.len;
          idx_r       <= idx_p1;
        end
      end
      OP_TRIM:     grant_r  <= rd_r.base;
      OP_SHIFT_DN: idx_r    <= idx_p1;
      OP_ST_NOFIT: status_r <= ST_NOFIT;
      OP_ST_FULL:  status_r <= ST_FULL;
      OP_ST_ZERO:  status_r <= ST_ZERO;
      OP_EVAL: begin
        acc_r    <= low_sum;
        lower_r  <= (idx_r != '0) && (low_end == {1'b0, base_r}) && !low_sum[ADDR_BITS];
        upper_r  <= upper_now;
        umerge_r <= upper_now && !up_sum[ADDR_BITS];
      end
      OP_PTR_CNT:  ptr_r    <= cnt_r;
      OP_SHIFT_UP: ptr_r    <= ptr_m1;
      OP_EMIT: begin
        if (emit) begin
          out_r.grant_base <= grant_r;
          out_r.status     <= status_r;
          out_r.free_slots <= slots_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/first_fit_resource_map.sv =====
// ---------------------------------------------------------------------------
// first_fit_resource_map
// first fit allocator over a sorted map of free extents, microcoded
//
// channel   dir  word fields
// in_req    in   command, req_size, req_base
// out_rsp   out  grant_base, status, free_slots
//
// one request at a time; the map memory does one read or one write a step
// scans read then test each extent passed, moves read then write each entry shifted
// a finished response waits in its register while the next request is taken
// a second response holds the sequencer until the first word is taken
// reset empties the map at once; no clearing pass
// ---------------------------------------------------------------------------
module first_fit_resource_map import ffrm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ffrm_req_if.sink   in_req,
  ffrm_rsp_if.source out_rsp
);

  ctl_t   ctl;
  flags_t fl;

  ffrm_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .fl    (fl),
    .ctl   (ctl)
  );

  ffrm_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .fl      (fl),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

endmodule

// ===== hdl/ffrm_checker.sv =====
// ---------------------------------------------------------------------------
// ffrm_checker
// port level checks of the first fit resource map
// ---------------------------------------------------------------------------
`include "first_fit_resource_map_macros.svh"

module ffrm_checker import ffrm_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);

  // response word holds until taken
  `FFRM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // one request at a time
  `FFRM_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

  // failed and zero size requests grant nothing
  `FFRM_ASSERT_NOW(a_fail_no_grant, clk, rst_n, out_valid && out_data.status != ST_DONE, out_data.grant_base == '0)

  // lost extent only with a full map
  `FFRM_ASSERT_NOW(a_full_no_slots, clk, rst_n, out_valid && out_data.status == ST_FULL, out_data.free_slots == '0)

  // slot count in range
  `FFRM_ASSERT_NOW(a_slots_range, clk, rst_n, out_valid, out_data.free_slots <= SLOTS_MAX)

endmodule

bind first_fit_resource_map ffrm_checker u_ffrm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .out_data  (out_rsp.data)
);

// ===== dv/first_fit_resource_map_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// first_fit_resource_map_checker
// watches the request and response channels of the resource map, keeps its
// own copy of the sorted free list, works out the response to every accepted
// request word and compares it field by field with the words that come out
// ---------------------------------------------------------------------------
module first_fit_resource_map_checker import ffrm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ffrm_req_if  req_mon,
  ffrm_rsp_if  rsp_mon,
  output int   fail_count,
  output int   pending,
  output int   rsp_total,
  output int   nofit_total,
  output int   full_total,
  output int   zero_total
);

  localparam int SPAN    = 1 << ADDR_BITS;
  localparam int LEN_MAX = SPAN - 1;

  addr_t ext_base [MAP_ENTRIES];
  addr_t ext_len  [MAP_ENTRIES];
  cnt_t  ext_count;
  cnt_t  slots;
  rsp_t  due_rsp_q [$];

  int mismatches = 0;
  int seen       = 0;
  int nofits     = 0;
  int fulls      = 0;
  int zeros      = 0;

  function automatic void drop_extent(input int pos);
    int i;
    for (i = pos; i + 1 < ext_count; i++) begin
      ext_base[i] = ext_base[i + 1];
      ext_len[i]  = ext_len[i + 1];
    end
    ext_count--;
    slots++;
  endfunction

  function automatic rsp_t serve_request(input req_t r);
    rsp_t o;
    int   size;
    int   a;
    int   fin;
    int   pos;
    int   i;
    bit   lower;
    bit   upper;
    o.grant_base = '0;
    o.status     = ST_DONE;
    size = int'(r.req_size);
    a    = int'(r.req_base);
    if (size == 0) begin
      o.status = ST_ZERO;
    end else if (r.command == CMD_ALLOC) begin
      o.status = ST_NOFIT;
      i = 0;
      while (i < ext_count && o.status == ST_NOFIT) begin
        if (int'(ext_len[i]) >= size) begin
          o.grant_base = ext_base[i];
          o.status     = ST_DONE;
          ext_base[i]  = ext_base[i] + addr_t'(size);
          ext_len[i]   = ext_len[i] - addr_t'(size);
          if (ext_len[i] == '0) drop_extent(i);
        end
        i++;
      end
    end else begin
      // clip at the top of the address space
      if (a + size > SPAN) size = SPAN - a;
      fin = a + size;
      pos = 0;
      while (pos < ext_count && int'(ext_base[pos]) <= a) pos++;
      lower = pos > 0 && int'(ext_base[pos - 1]) + int'(ext_len[pos - 1]) == a &&
              int'(ext_len[pos - 1]) + size <= LEN_MAX;
      upper = pos < ext_count && fin == int'(ext_base[pos]);
      if (lower) begin
        ext_len[pos - 1] = addr_t'(int'(ext_len[pos - 1]) + size);
        if (upper && int'(ext_len[pos - 1]) + int'(ext_len[pos]) <= LEN_MAX) begin
          ext_len[pos - 1] = ext_len[pos - 1] + ext_len[pos];
          drop_extent(pos);
        end
      end else if (upper && int'(ext_len[pos]) + size <= LEN_MAX) begin
        ext_base[pos] = addr_t'(a);
        ext_len[pos]  = addr_t'(int'(ext_len[pos]) + size);
      end else if (slots == '0) begin
        o.status = ST_FULL;
      end else begin
        for (i = ext_count; i > pos; i--) begin
          ext_base[i] = ext_base[i - 1];
          ext_len[i]  = ext_len[i - 1];
        end
        ext_base[pos] = addr_t'(a);
        ext_len[pos]  = addr_t'(size);
        ext_count++;
        slots--;
      end
    end
    o.free_slots = slots;
    return o;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t got;
    rsp_t want;
    if (!rst_n) begin
      ext_count = '0;
      slots     = SLOTS_MAX;
      due_rsp_q.delete();
    end else begin
      if (req_mon.valid && req_mon.ready) due_rsp_q.push_back(serve_request(req_mon.data));
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.data;
        seen++;
        if (got.status == ST_NOFIT) nofits++;
        if (got.status == ST_FULL) fulls++;
        if (got.status == ST_ZERO) zeros++;
        if (due_rsp_q.size() == 0) begin
          $display("%0t: response word with nothing expected: grant_base %h status %0d slots %0d",
                   $time, got.grant_base, got.status, got.free_slots);
          mismatches++;
        end else begin
          want = due_rsp_q.pop_front();
          if (got.grant_base !== want.grant_base) begin
            $display("%0t: grant_base expected %h actual %h",
                     $time, want.grant_base, got.grant_base);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            mismatches++;
          end
          if (got.free_slots !== want.free_slots) begin
            $display("%0t: free_slots expected %0d actual %0d",
                     $time, want.free_slots, got.free_slots);
            mismatches++;
          end
        end
      end
    end
    fail_count  <= mismatches;
    pending     <= due_rsp_q.size();
    rsp_total   <= seen;
    nofit_total <= nofits;
    full_total  <= fulls;
    zero_total  <= zeros;
  end

endmodule

// ===== dv/first_fit_resource_map_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// first_fit_resource_map_test
// drives allocate and free request words into the resource map: a directed
// walk through merges, clipping, refused merges and misses, then random
// sequences that churn, fill and drain the map under bursty input and a
// stalling output; the checker beside the block judges every response
// ---------------------------------------------------------------------------
module first_fit_resource_map_test import ffrm_pkg::*; ();

  localparam int RUN_WORDS   = 1700;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 200;
  localparam int LIMIT_NS    = 60_000_000;

  logic clk;
  logic rst_n;
  bit   hold_rq;
  int   burst_left;
  int   live_words;
  int   map_fails;
  int   map_pending;
  int   rsp_total;
  int   nofit_total;
  int   full_total;
  int   zero_total;

  ffrm_req_if in_req ();
  ffrm_rsp_if out_rsp ();

  first_fit_resource_map dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  first_fit_resource_map_checker map_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (in_req),
    .rsp_mon     (out_rsp),
    .fail_count  (map_fails),
    .pending     (map_pending),
    .rsp_total   (rsp_total),
    .nofit_total (nofit_total),
    .full_total  (full_total),
    .zero_total  (zero_total)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_word(input cmd_t c, input int size, input int base);
    req_t w;
    int   gap;
    w.command  = c;
    w.req_size = addr_t'(size);
    w.req_base = addr_t'(base);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_req.valid <= 1'b1;
    in_req.data  <= w;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    if (w.req_size != '0) live_words++;
  endtask

  task automatic drain_wait();
    in_req.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (map_pending != 0);
  endtask

  // output side: random stall stretches plus requested long hold-offs
  initial begin : receiver
    int stretch;
    int mode;
    stretch = 0;
    mode    = 0;
    out_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rq) begin
        out_rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rq = 1'b0;
      end
      if (stretch == 0) begin
        stretch = $urandom_range(1, 64);
        mode    = $urandom_range(0, 3);
      end
      stretch--;
      case (mode)
        2:       out_rsp.ready <= 1'($urandom_range(0, 1));
        3:       out_rsp.ready <= ($urandom_range(0, 3) == 0);
        default: out_rsp.ready <= 1'b1;
      endcase
    end
  end

  initial begin : stimulus
    int seq_no;
    int kind;
    int n;
    int step;
    int k;
    int base0;
    hold_rq    = 1'b0;
    burst_left = 0;
    live_words = 0;
    rst_n        <= 1'b0;
    in_req.valid <= 1'b0;
    in_req.data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed walk
    send_word(CMD_ALLOC, 'h0001, 'h0000);
    send_word(CMD_ALLOC, 'h0000, 'hFFFF);
    send_word(CMD_FREE,  'h0000, 'h1234);
    send_word(CMD_FREE,  'h0100, 'h0100);
    send_word(CMD_FREE,  'h0100, 'h0300);
    send_word(CMD_FREE,  'h0100, 'h0200);
    send_word(CMD_FREE,  'h0080, 'h0000);
    send_word(CMD_FREE,  'h0080, 'h0080);
    send_word(CMD_FREE,  'h0100, 'h0500);
    send_word(CMD_FREE,  'h0080, 'h0400);
    send_word(CMD_FREE,  'h0040, 'h04C0);
    send_word(CMD_ALLOC, 'h0480, 'h5A5A);
    send_word(CMD_ALLOC, 'h0010, 'hA5A5);
    send_word(CMD_ALLOC, 'hFFFF, 'h0000);
    send_word(CMD_FREE,  'hFFFF, 'hFFF0);
    send_word(CMD_FREE,  'h7FF0, 'h8000);
    send_word(CMD_FREE,  'h04D0, 'h0000);
    send_word(CMD_FREE,  'h7A00, 'h0600);
    send_word(CMD_FREE,  'h0001, 'h8000);
    send_word(CMD_ALLOC, 'h8000, 'h0000);
    send_word(CMD_ALLOC, 'h8000, 'h0000);
    send_word(CMD_ALLOC, 'h0001, 'h0000);
    send_word(CMD_FREE,  'hFFF0, 'h0000);
    send_word(CMD_FREE,  'h0010, 'hFFF0);
    send_word(CMD_ALLOC, 'hFFFF, 'hFFFF);
    drain_wait();

    seq_no = 0;
    while (live_words < RUN_WORDS) begin
      seq_no++;
      if (seq_no == 6 || $urandom_range(0, 59) == 0) hold_rq = 1'b1;
      if (seq_no == 12 || $urandom_range(0, 39) == 0) drain_wait();
      kind = $urandom_range(0, 99);
      n    = $urandom_range(8, 30);
      if (kind < 35) begin
        // churn on a grid so that frees touch and merge often
        step = 1 << (4 * $urandom_range(0, 3));
        repeat (n) begin
          if ($urandom_range(0, 1) == 1)
            send_word(CMD_FREE, step * $urandom_range(1, 4), step * $urandom_range(0, 15));
          else
            send_word(CMD_ALLOC, step * $urandom_range(1, 4), $urandom);
        end
      end else if (kind < 55) begin
        // isolated small extents, pushes the map to full
        base0 = $urandom_range(0, 65535);
        n     = $urandom_range(40, 80);
        for (k = 0; k < n; k++) send_word(CMD_FREE, $urandom_range(1, 2), base0 + 4 * k);
      end else if (kind < 75) begin
        repeat (n)
          send_word(CMD_ALLOC,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 16),
                    $urandom);
      end else begin
        repeat (n)
          send_word(cmd_t'($urandom_range(0, 1)),
                    ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, 65535),
                    $urandom_range(0, 65535));
      end
    end

    drain_wait();
    repeat (SETTLE) @(posedge clk);
    $display("run covered %0d live request words in %0d sequences, %0d responses checked",
             live_words, seq_no, rsp_total);
    $display("responses with no fit %0d, map full %0d, zero size %0d",
             nofit_total, full_total, zero_total);
    if (map_fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
